// ----- rtl/oilq_pkg.sv -----
// Shared types and constants for the ordered insert list queue.
package oilq_pkg;

	localparam int WORD_W    = 32;
	localparam int DEPTH_DEF = 16;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_INSERT     = 2'd1,
		ACT_REMOVE     = 2'd2,
		ACT_CLEAR      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY_RM   = 2'd1,
		ST_FULL_DROP  = 2'd2,
		ST_RSVD       = 2'd3
	} status_t;

	typedef logic signed [WORD_W-1:0] word_t;

	// Operation broadcast to every cell for one beat.
	typedef struct packed {
		logic  do_ins;
		logic  front;
		logic  do_rem;
		logic  do_clr;
		word_t value;
	} cell_op_t;

endpackage

// ----- rtl/oilq_cell.sv -----
// One storage cell of the ordered list chain.
module oilq_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  oilq_pkg::cell_op_t op,
	input  oilq_pkg::word_t   left_value,
	input  logic              left_valid,
	input  oilq_pkg::word_t   right_value,
	input  logic              right_valid,
	input  logic              found_in,
	output logic              found_out,
	output oilq_pkg::word_t   value_q,
	output logic              valid_q
);
	import oilq_pkg::*;

	logic hit;

	// hit: the new word lands in this cell
	always_comb begin
		if (HEAD) begin
			hit = op.front | ~valid_q | (op.value < value_q);
		end else begin
			hit = ~found_in & ~(valid_q & (value_q < op.value));
		end
	end

	assign found_out = found_in | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.do_clr) begin
			valid_q <= 1'b0;
		end else if (op.do_rem) begin
			valid_q <= right_valid;
		end else if (op.do_ins) begin
			if (hit) begin
				valid_q <= 1'b1;
			end else if (found_in) begin
				valid_q <= left_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.do_rem) begin
			value_q <= right_value;
		end else if (op.do_ins) begin
			if (hit) begin
				value_q <= op.value;
			end else if (found_in) begin
				value_q <= left_value;
			end
		end
	end

endmodule

// ----- rtl/ordered_insert_list_queue.sv -----
// Top level of the ordered insert list queue: cell chain, count and result register.
//
// Bounded ordered list of signed words kept in a row of DEPTH cells, head in cell 0.
// Command channel: an item is taken when start is high and busy is low. busy is
// held low, so a new item may be offered every cycle.
// Actions: push front, ordered insert, remove first, clear all.
// Every cell compares its word with the incoming one at once; a found flag ripples
// along the row so that exactly one cell takes the new word, cells beyond it take
// their left neighbour and cells before it hold. Remove shifts every cell left.
// Result channel: done pulses for one cycle, the cycle after the beat is taken,
// carrying head_value, entry_count, is_empty and status. Throughput is one item
// per cycle; the length of the found ripple through the row sets the clock
// period for large DEPTH.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Reset clears all valid bits and the count: the list starts empty, no result
// pending. Words in cells carry no reset; invalid cells are never reported.
// Insert into a full list is dropped (status 2); remove on empty flags status 1.
module ordered_insert_list_queue #(
	parameter int DEPTH = oilq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic signed [oilq_pkg::WORD_W-1:0] value,
	output logic                        done,
	output logic signed [oilq_pkg::WORD_W-1:0] head_value,
	output logic [oilq_pkg::COUNT_W-1:0] entry_count,
	output logic                        is_empty,
	output logic [1:0]                  status
);
	import oilq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	status_t          status_q;

	action_t  act;
	cell_op_t op;
	logic     full, empty, take;
	status_t  status_d;

	word_t cell_value [DEPTH];
	logic  cell_valid [DEPTH];
	logic  found      [DEPTH+1];

	assign busy  = 1'b0;
	assign take  = start & ~busy;
	assign act   = action_t'(action);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// decode the beat into the operation every cell sees
	always_comb begin
		op.value  = value;
		op.front  = 1'b0;
		op.do_ins = 1'b0;
		op.do_rem = 1'b0;
		op.do_clr = 1'b0;
		status_d  = ST_OK;
		unique case (act)
			ACT_PUSH_FRONT: begin
				op.front = 1'b1;
				if (full) begin
					status_d = ST_FULL_DROP;
				end else begin
					op.do_ins = take;
				end
			end
			ACT_INSERT: begin
				if (full) begin
					status_d = ST_FULL_DROP;
				end else begin
					op.do_ins = take;
				end
			end
			ACT_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY_RM;
				end else begin
					op.do_rem = take;
				end
			end
			ACT_CLEAR: begin
				op.do_clr = take;
			end
			default: begin
				op.do_clr = 1'b0;
			end
		endcase
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t lv, rv;
		logic  lvld, rvld;

		if (i == 0) begin : g_left_end
			assign lv   = '0;
			assign lvld = 1'b0;
		end else begin : g_left
			assign lv   = cell_value[i-1];
			assign lvld = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_end
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_right
			assign rv   = cell_value[i+1];
			assign rvld = cell_valid[i+1];
		end

		oilq_cell #(
			.HEAD (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.left_value  (lv),
			.left_valid  (lvld),
			.right_value (rv),
			.right_valid (rvld),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.value_q     (cell_value[i]),
			.valid_q     (cell_valid[i])
		);
	end

	// entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= take;
			if (take) begin
				status_q <= status_d;
			end
			priority if (op.do_clr) begin
				count_q <= '0;
			end else if (op.do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end else if (op.do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// result reflects the state left by the beat of the previous cycle
	assign done        = done_q;
	assign head_value  = cell_valid[0] ? cell_value[0] : '0;
	assign entry_count = COUNT_W'(count_q);
	assign is_empty    = empty;
	assign status      = status_q;

endmodule
